// ----- sv/tealk_pkg.sv -----
// Shared constants, types and helpers of the 64-bit TEA-like block encryptor.
package tealk_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned KEY_IDX_W   = $clog2(KEY_WORDS);

  localparam logic [WORD_W-1:0] GOLDEN_DELTA = 64'h9e3779b97f4a7c15;

  localparam int unsigned SHL_A = 7;
  localparam int unsigned SHR_A = 12;
  localparam int unsigned SHL_B = 16;
  localparam int unsigned SHR_B = 8;

  localparam logic [KEY_IDX_W-1:0] KEY0_IDX = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY1_IDX = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY2_IDX = 2'd2;
  localparam logic [KEY_IDX_W-1:0] KEY3_IDX = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t k3;
    word_t k2;
    word_t k1;
    word_t k0;
  } key_set_t;

  // Running sum after round r (r counted from 0).
  function automatic word_t round_sum(input int unsigned r);
    word_t acc;
    acc = '0;
    for (int unsigned i = 0; i <= r; i++) begin
      acc = acc + GOLDEN_DELTA;
    end
    return acc;
  endfunction

endpackage

// ----- sv/tealk_round.sv -----
// One cipher round as two register stages: first-word update, then second-word update.
module tealk_round
  import tealk_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  key_set_t key_i,
  input  word_t    sum_i,
  input  logic     valid_i,
  input  word_t    a_i,
  input  word_t    b_i,
  output logic     valid_o,
  output word_t    a_o,
  output word_t    b_o
);

  logic  mid_vld_q;
  logic  out_vld_q;
  word_t a_mid_d, a_mid_q, b_mid_q;
  word_t b_out_d, a_out_q, b_out_q;

  assign a_mid_d = a_i + (((b_i << SHL_A) + key_i.k0) ^ (b_i + sum_i)
                          ^ ((b_i >> SHR_A) + key_i.k1));
  assign b_out_d = b_mid_q + (((a_mid_q << SHL_B) + key_i.k2) ^ (a_mid_q + sum_i)
                              ^ ((a_mid_q >> SHR_B) + key_i.k3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      mid_vld_q <= valid_i;
      out_vld_q <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mid_q <= a_mid_d;
      b_mid_q <= b_i;
      a_out_q <= a_mid_q;
      b_out_q <= b_out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign a_o     = a_out_q;
  assign b_o     = b_out_q;

endmodule

// ----- sv/tea_like_block_encrypt_64bit_words_top.sv -----
// Top level of the pipelined 64-bit TEA-like block encryptor.
//
// Input beats arrive on the s_axis group: tdata carries plain_low in bits
// [63:0] and plain_high in bits [127:64]. Encrypted blocks leave on the
// m_axis group with cipher_low in [63:0] and cipher_high in [127:64].
// The four key words are written through cfg_we_i / cfg_index_i /
// cfg_wdata_i; write them only while no block is in flight.
//
// Each round is two register stages (first-word and second-word update),
// so a block passes through both stages of every round from accept to valid output.
// One block is accepted per cycle while the output side takes results.
//
// Reset clears the key words to zero and empties the pipeline.
// When the receiver holds m_axis_tready low with a result pending, the
// whole pipeline freezes and s_axis_tready drops; nothing is lost or
// repeated, and flow resumes in the cycle tready returns.
module tea_like_block_encrypt_64bit_words_top
  import tealk_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [2*WORD_W-1:0]     s_axis_tdata,   // plain_low, plain_high
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [2*WORD_W-1:0]     m_axis_tdata,   // cipher_low, cipher_high
  input  logic                    cfg_we_i,
  input  logic [KEY_IDX_W-1:0]    cfg_index_i,
  input  logic [WORD_W-1:0]       cfg_wdata_i
);

  key_set_t               key_q;
  logic                   en;
  logic                   in_beat;
  logic [ROUND_COUNT:0]   vld_c;
  word_t                  a_c [ROUND_COUNT+1];
  word_t                  b_c [ROUND_COUNT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        KEY0_IDX: key_q.k0 <= cfg_wdata_i;
        KEY1_IDX: key_q.k1 <= cfg_wdata_i;
        KEY2_IDX: key_q.k2 <= cfg_wdata_i;
        KEY3_IDX: key_q.k3 <= cfg_wdata_i;
        default:  key_q    <= key_q;
      endcase
    end
  end

  assign en            = !vld_c[ROUND_COUNT] || m_axis_tready;
  assign s_axis_tready = en;
  assign in_beat       = s_axis_tvalid && en;

  assign vld_c[0] = in_beat;
  assign a_c[0]   = s_axis_tdata[WORD_W-1:0];
  assign b_c[0]   = s_axis_tdata[2*WORD_W-1:WORD_W];

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    localparam word_t RoundSum = round_sum(r);

    tealk_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .key_i   (key_q),
      .sum_i   (RoundSum),
      .valid_i (vld_c[r]),
      .a_i     (a_c[r]),
      .b_i     (b_c[r]),
      .valid_o (vld_c[r+1]),
      .a_o     (a_c[r+1]),
      .b_o     (b_c[r+1])
    );
  end

  assign m_axis_tvalid = vld_c[ROUND_COUNT];
  assign m_axis_tdata  = {b_c[ROUND_COUNT], a_c[ROUND_COUNT]};

  // Frozen pipeline keeps every round's output valid bit.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_c[ROUND_COUNT:1]))
    else $error("valid bits moved while the pipeline was stalled");

  // Advancing through both stages of a round with no stall moves each valid bit exactly one round forward.
  a_round_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && $past(en) && $past(rst_ni) && $past(rst_ni, 2))
      |=> vld_c[ROUND_COUNT:1] == $past(vld_c[ROUND_COUNT-1:0], 2))
    else $error("valid bit lost or duplicated across a round");

  // A waiting result implies the input side is held off and the result stays valid.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !in_beat ##1 m_axis_tvalid)
    else $error("input beat taken or result dropped during output stall");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the 64-bit TEA-like block encryptor.
class tea64_tracker;
  typedef struct {
    tealk_pkg::word_t lo;
    tealk_pkg::word_t hi;
  } cipher_pair_t;

  tealk_pkg::word_t key_word[tealk_pkg::KEY_WORDS];
  cipher_pair_t     cipher_due[$];
  int unsigned      fail_count;
  int unsigned      blocks_checked;

  function new();
    foreach (key_word[i]) key_word[i] = '0;
    fail_count     = 0;
    blocks_checked = 0;
  endfunction

  function void set_key(input logic [tealk_pkg::KEY_IDX_W-1:0] idx,
                        input tealk_pkg::word_t value);
    key_word[idx] = value;
  endfunction

  function cipher_pair_t encipher(input tealk_pkg::word_t lo, input tealk_pkg::word_t hi);
    tealk_pkg::word_t a;
    tealk_pkg::word_t b;
    tealk_pkg::word_t acc;
    cipher_pair_t     res;
    a   = lo;
    b   = hi;
    acc = '0;
    for (int r = 0; r < tealk_pkg::ROUND_COUNT; r++) begin
      acc = acc + tealk_pkg::GOLDEN_DELTA;
      a = a + (((b << tealk_pkg::SHL_A) + key_word[0]) ^ (b + acc)
               ^ ((b >> tealk_pkg::SHR_A) + key_word[1]));
      b = b + (((a << tealk_pkg::SHL_B) + key_word[2]) ^ (a + acc)
               ^ ((a >> tealk_pkg::SHR_B) + key_word[3]));
    end
    res.lo = a;
    res.hi = b;
    return res;
  endfunction

  function void note_plain(input tealk_pkg::word_t lo, input tealk_pkg::word_t hi);
    cipher_due.push_back(encipher(lo, hi));
  endfunction

  function void check_cipher(input tealk_pkg::word_t lo, input tealk_pkg::word_t hi);
    cipher_pair_t exp_pair;
    if (cipher_due.size() == 0) begin
      $error("unexpected cipher beat: cipher_low %h cipher_high %h", lo, hi);
      fail_count++;
      return;
    end
    exp_pair = cipher_due.pop_front();
    blocks_checked++;
    if (exp_pair.lo !== lo) begin
      $error("cipher_low: expected %h, got %h", exp_pair.lo, lo);
      fail_count++;
    end
    if (exp_pair.hi !== hi) begin
      $error("cipher_high: expected %h, got %h", exp_pair.hi, hi);
      fail_count++;
    end
  endfunction

  function int unsigned pending();
    return cipher_due.size();
  endfunction

  function void close_out();
    if (cipher_due.size() != 0) begin
      $error("%0d cipher blocks never arrived", cipher_due.size());
      fail_count++;
    end
  endfunction
endclass

module tb_top;
  import tealk_pkg::*;

  localparam word_t ONES = '1;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [2*WORD_W-1:0] s_axis_tdata  = '0;  // plain_low, plain_high
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [2*WORD_W-1:0] m_axis_tdata;        // cipher_low, cipher_high
  logic                cfg_we_i      = 1'b0;
  logic [KEY_IDX_W-1:0] cfg_index_i  = '0;
  logic [WORD_W-1:0]   cfg_wdata_i   = '0;

  tea64_tracker tracker = new();

  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int unsigned blocks_sent = 0;
  int unsigned key_sets = 1;
  int unsigned rx_stall = 0;

  tea_like_block_encrypt_64bit_words_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_cipher(m_axis_tdata[WORD_W-1:0], m_axis_tdata[2*WORD_W-1:WORD_W]);
        rx_stall = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONES;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic set_keys(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
    word_t vals[KEY_WORDS];
    logic [KEY_IDX_W-1:0] idx_name[KEY_WORDS];
    vals     = '{k0, k1, k2, k3};
    idx_name = '{KEY0_IDX, KEY1_IDX, KEY2_IDX, KEY3_IDX};
    for (int i = 0; i < KEY_WORDS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx_name[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      tracker.set_key(idx_name[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    key_sets++;
  endtask

  task automatic send_block(input word_t lo, input word_t hi);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_plain(lo, hi);
    blocks_sent++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() > 0);
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 48 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      if (i == count / 2) hold_until_drained();
      send_block(rand_word(), rand_word());
    end
    hold_until_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero key straight out of reset, corner blocks at full rate
    send_block('0, '0);
    send_block(ONES, ONES);
    send_block('0, ONES);
    send_block(ONES, '0);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_block(64'h1, '0);
    send_block(64'h8000_0000_0000_0000, '0);
    send_block('0, 64'h1);
    send_block('0, 64'h8000_0000_0000_0000);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    hold_until_drained();
    set_keys(ONES, ONES, ONES, ONES);
    send_block('0, '0);
    send_block(ONES, ONES);
    send_block(64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe);
    hold_until_drained();
    set_keys(ONES, '0, 64'h8000_0000_0000_0000, 64'h1);
    send_block('0, '0);
    send_block(ONES, '0);
    send_block('0, ONES);
    hold_until_drained();

    set_keys('0, '0, '0, '0);
    run_random(150);
    set_keys(ONES, ONES, ONES, ONES);
    run_random(200);
    for (int p = 0; p < 4; p++) begin
      set_keys({$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      run_random(200);
    end
    set_keys('0, ONES, '0, 64'h8000_0000_0000_0000);
    run_random(100);

    repeat (80) @(posedge clk_i);
    tracker.close_out();
    $display("Encrypted %0d blocks under %0d key settings (zero, all-ones, mixed, random).",
             blocks_sent, key_sets);
    $display("Checked %0d cipher beats with random gaps and stalls on both streams.",
             tracker.blocks_checked);
    if (tracker.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
